/* rtl/sde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sde_pkg;

    localparam int MaxTerms   = 3;
    localparam int TermIdxW   = 2;
    localparam int WaveW      = 14;
    localparam int FracW      = 20;
    localparam int ValueW     = 24;
    localparam int StatusW    = 2;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 20;
    localparam int NumW       = 52;
    localparam int DenW       = 28;
    localparam int RadW       = 48;
    localparam int RootW      = 24;

    localparam logic [StatusW-1:0] StatusOk       = 2'd0;
    localparam logic [StatusW-1:0] StatusSingular = 2'd1;
    localparam logic [StatusW-1:0] StatusSat      = 2'd2;

    localparam logic [CfgIdxW-1:0] RegTermCount = 3'd0;
    localparam logic [CfgIdxW-1:0] RegOffset    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegStrOne    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegResOne    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegStrTwo    = 3'd4;
    localparam logic [CfgIdxW-1:0] RegResTwo    = 3'd5;
    localparam logic [CfgIdxW-1:0] RegStrThree  = 3'd6;
    localparam logic [CfgIdxW-1:0] RegResThree  = 3'd7;

    localparam logic OpEps   = 1'b0;
    localparam logic OpIndex = 1'b1;

    typedef enum logic {
        ITER_DIV,
        ITER_SQRT
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_ctrl_t;

endpackage
`default_nettype wire

/* rtl/sellmeier_dispersion_eval.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sellmeier dispersion evaluator: per transaction, eps = |1 + n0^2 + sum ni^2*W^2/(W^2-Li^2)|
// in unsigned Q.16 (operation 0) or floor(sqrt(eps*mu)) (operation 1), with status 0 ok,
// 1 singular (zero wavelength or wavelength on an active resonance), 2 saturated. One item
// at a time: a shared 32x32 multiplier and a one-bit-per-cycle divide/square-root unit
// do all the work. The per-term division dominates the time from input transaction to
// m_tvalid, and operation 1 adds a multiply and a square root after the terms. A singular
// item goes straight from idle to the output state. s_tready is high only while
// idle, and a result held by m_tready stalls the block before it returns to idle.
module sellmeier_dispersion_eval
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [13:0] wavelength, [33:14] permeability, zero pad
    input  wire logic        s_tuser,   // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [23:0] value
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_W2, S_N0, S_ACC0, S_TS, S_TL, S_T1, S_T2, S_DIV,
        S_FIN, S_ML, S_MM, S_MH, S_SQ, S_OUT
    } state_t;

    state_t state_reg;

    logic [1:0]  term_count_reg;
    logic [19:0] offset_reg;
    logic [19:0] str_reg [sde_pkg::MaxTerms];
    logic [13:0] res_reg [sde_pkg::MaxTerms];

    logic        op_reg;
    logic [13:0] w_reg;
    logic [19:0] mu_reg;
    logic [1:0]  t_reg;
    logic [1:0]  n_reg;
    logic [27:0] w2_reg;
    logic [23:0] s_reg;
    logic [27:0] den_reg;
    logic        neg_reg;
    logic signed [56:0] acc_reg;
    logic [55:0] eps_reg;
    logic [43:0] lo_reg;
    logic [23:0] val_reg;
    logic [1:0]  stat_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [23:0] sq_rnd;
    logic [1:0]  n_eff;
    logic        singular;
    logic [13:0] w_in;
    logic [27:0] l2;
    logic [67:0] prod;
    logic [56:0] qext;
    sde_pkg::iter_ctrl_t iter_ctrl;
    logic        iter_done;
    logic [sde_pkg::NumW-1:0] iter_q;
    logic [sde_pkg::NumW-1:0] iter_a;

    sde_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    sde_iter u_iter
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (iter_ctrl),
        .opa    (iter_a),
        .opb    (den_reg),
        .done   (iter_done),
        .result (iter_q)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    assign w_in   = s_tdata[13:0];
    assign n_eff  = (term_count_reg == 2'd0) ? 2'd1 : term_count_reg;
    assign sq_rnd = 24'((mul_p[39:0] + 40'd32768) >> 16);
    assign l2     = mul_p[27:0];
    assign prod   = {24'd0, lo_reg} + {mul_p[43:0], 24'd0};
    assign qext   = 57'(iter_q);

    always_comb
    begin
        singular = (w_in == 14'd0) || (res_reg[0] == w_in)
                || (n_eff >= 2'd2 && res_reg[1] == w_in)
                || (n_eff == 2'd3 && res_reg[2] == w_in);
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        iter_ctrl = '{start: 1'b0, mode: sde_pkg::ITER_DIV};
        iter_a    = mul_p[sde_pkg::NumW-1:0];
        unique case (state_reg)
            S_W2:
            begin
                mul_a = 32'(w_reg);
                mul_b = 32'(w_reg);
            end
            S_N0:
            begin
                mul_a = 32'(offset_reg);
                mul_b = 32'(offset_reg);
            end
            S_TS:
            begin
                mul_a = 32'(str_reg[t_reg]);
                mul_b = 32'(str_reg[t_reg]);
            end
            S_TL:
            begin
                mul_a = 32'(res_reg[t_reg]);
                mul_b = 32'(res_reg[t_reg]);
            end
            S_T1:
            begin
                mul_a = 32'(s_reg);
                mul_b = 32'(w2_reg);
            end
            S_T2:
            begin
                iter_ctrl = '{start: 1'b1, mode: sde_pkg::ITER_DIV};
            end
            S_ML:
            begin
                mul_a = 32'(eps_reg[23:0]);
                mul_b = 32'(mu_reg);
            end
            S_MM:
            begin
                mul_a = 32'(eps_reg[47:24]);
                mul_b = 32'(mu_reg);
            end
            S_MH:
            begin
                iter_ctrl = '{start: 1'b1, mode: sde_pkg::ITER_SQRT};
                iter_a    = sde_pkg::NumW'(prod[47:0]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            term_count_reg <= 2'd1;
            offset_reg     <= '0;
            for (int i = 0; i < sde_pkg::MaxTerms; i++)
            begin
                str_reg[i] <= '0;
                res_reg[i] <= '0;
            end
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sde_pkg::RegTermCount: term_count_reg <= cfg_data[1:0];
                    sde_pkg::RegOffset:    offset_reg     <= cfg_data;
                    sde_pkg::RegStrOne:    str_reg[0]     <= cfg_data;
                    sde_pkg::RegResOne:    res_reg[0]     <= cfg_data[13:0];
                    sde_pkg::RegStrTwo:    str_reg[1]     <= cfg_data;
                    sde_pkg::RegResTwo:    res_reg[1]     <= cfg_data[13:0];
                    sde_pkg::RegStrThree:  str_reg[2]     <= cfg_data;
                    sde_pkg::RegResThree:  res_reg[2]     <= cfg_data[13:0];
                    default:
                    begin
                    end
                endcase
            end

            // S_OUT reloads the output register itself
            if (out_valid_reg && m_tready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg <= s_tuser;
                        w_reg  <= w_in;
                        mu_reg <= s_tdata[33:14];
                        n_reg  <= n_eff;
                        t_reg  <= 2'd0;
                        if (singular)
                        begin
                            val_reg   <= '0;
                            stat_reg  <= sde_pkg::StatusSingular;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_W2;
                        end
                    end
                end
                S_W2:   state_reg <= S_N0;
                S_N0:
                begin
                    w2_reg    <= mul_p[27:0];
                    state_reg <= S_ACC0;
                end
                S_ACC0:
                begin
                    acc_reg   <= 57'(sq_rnd) + 57'sd65536;
                    state_reg <= S_TS;
                end
                S_TS:   state_reg <= S_TL;
                S_TL:
                begin
                    s_reg     <= sq_rnd;
                    state_reg <= S_T1;
                end
                S_T1:
                begin
                    // l^2 arrives now; the num product follows next cycle
                    den_reg   <= (w2_reg > l2) ? (w2_reg - l2) : (l2 - w2_reg);
                    neg_reg   <= (res_reg[t_reg] > w_reg);
                    state_reg <= S_T2;
                end
                S_T2:   state_reg <= S_DIV;
                S_DIV:
                begin
                    if (iter_done)
                    begin
                        acc_reg <= neg_reg ? (acc_reg - $signed(qext))
                                           : (acc_reg + $signed(qext));
                        if (t_reg == n_reg - 2'd1)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            t_reg     <= t_reg + 2'd1;
                            state_reg <= S_TS;
                        end
                    end
                end
                S_FIN:
                begin
                    // eps taken from the accumulator magnitude
                    eps_reg <= acc_reg[56] ? 56'(-acc_reg) : 56'(acc_reg);
                    if (op_reg == sde_pkg::OpEps)
                    begin
                        state_reg <= S_OUT;
                        if ((acc_reg[56] ? 57'(-acc_reg) : 57'(acc_reg)) > 57'd16777215)
                        begin
                            val_reg  <= '1;
                            stat_reg <= sde_pkg::StatusSat;
                        end
                        else
                        begin
                            val_reg  <= acc_reg[56] ? 24'(-acc_reg) : 24'(acc_reg);
                            stat_reg <= sde_pkg::StatusOk;
                        end
                    end
                    else
                    begin
                        state_reg <= S_ML;
                    end
                end
                S_ML:   state_reg <= S_MM;
                S_MM:
                begin
                    // low partial product of eps * mu is ready; high half issued now
                    state_reg <= S_MH;
                    lo_reg    <= mul_p[43:0];
                end
                S_MH:
                begin
                    if (mu_reg != 20'd0 && (eps_reg[55:48] != 8'd0 || prod[67:48] != 20'd0))
                    begin
                        val_reg   <= '1;
                        stat_reg  <= sde_pkg::StatusSat;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (iter_done)
                    begin
                        val_reg   <= iter_q[23:0];
                        stat_reg  <= sde_pkg::StatusOk;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= val_reg;
                        out_user_reg  <= stat_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/sde_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module sde_mul
(
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {32'd0, a} * {32'd0, b};
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* rtl/sde_iter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider and digit-by-digit square root, one result bit per cycle.
module sde_iter
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sde_pkg::iter_ctrl_t     ctrl,
    input  wire logic [sde_pkg::NumW-1:0] opa,
    input  wire logic [sde_pkg::DenW-1:0] opb,
    output logic                         done,
    output logic [sde_pkg::NumW-1:0]     result
);

    logic [sde_pkg::NumW-1:0] work_reg, work_next;
    logic [sde_pkg::NumW-1:0] quo_reg, quo_next;
    logic [sde_pkg::DenW:0]   rem_reg, rem_next;
    logic [sde_pkg::DenW-1:0] den_reg;
    logic [5:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    sde_pkg::iter_mode_t      mode_reg;

    logic [sde_pkg::DenW:0]   rem_sh;
    logic [sde_pkg::DenW:0]   trial;

    always_comb
    begin
        work_next = work_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = '0;
        trial     = '0;
        if (ctrl.start)
        begin
            work_next = opa;
            quo_next  = '0;
            rem_next  = '0;
            busy_next = 1'b1;
            cnt_next  = (ctrl.mode == sde_pkg::ITER_DIV) ? 6'(sde_pkg::NumW - 1)
                                                         : 6'(sde_pkg::RootW - 1);
        end
        else if (busy_reg)
        begin
            if (mode_reg == sde_pkg::ITER_DIV)
            begin
                rem_sh    = {rem_reg[sde_pkg::DenW-1:0], work_reg[sde_pkg::NumW-1]};
                trial     = {1'b0, den_reg};
                work_next = {work_reg[sde_pkg::NumW-2:0], 1'b0};
            end
            else
            begin
                rem_sh    = {rem_reg[sde_pkg::DenW-2:0], work_reg[sde_pkg::RadW-1 -: 2]};
                trial     = (sde_pkg::DenW + 1)'({quo_reg[sde_pkg::RootW-1:0], 2'b01});
                work_next = {work_reg[sde_pkg::NumW-3:0], 2'b00};
            end
            if (rem_sh >= trial)
            begin
                rem_next = rem_sh - trial;
                quo_next = {quo_reg[sde_pkg::NumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[sde_pkg::NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        if (ctrl.start)
        begin
            den_reg  <= opb;
            mode_reg <= ctrl.mode;
        end
    end

    assign done   = done_reg;
    assign result = quo_reg;

endmodule
`default_nettype wire
